FILE: sv/cdf_pkg.sv
// shared types, register codes and the divider step for the cavity density factor block
`default_nettype none
package cdf_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int MAG_W = 25;
	localparam int DEN_W = 24;
	localparam int DAY_UNITS = 6144;

	localparam logic [2:0] REG_ILAT_MID        = 3'd0;
	localparam logic [2:0] REG_ILAT_HALF_WIDTH = 3'd1;
	localparam logic [2:0] REG_MLT_MID         = 3'd2;
	localparam logic [2:0] REG_MLT_HALF_WIDTH  = 3'd3;
	localparam logic [2:0] REG_TOP_HEIGHT      = 3'd4;
	localparam logic [2:0] REG_FLOOR_HEIGHT    = 3'd5;
	localparam logic [2:0] REG_DEPTH_SCALE     = 3'd6;
	localparam logic [2:0] REG_CAVITY_ENABLED  = 3'd7;

	localparam int LANE_H = 0;
	localparam int LANE_X = 1;
	localparam int LANE_Y = 2;

	typedef struct packed {
		logic [14:0] ilat_mid;
		logic [14:0] ilat_half_width;
		logic [12:0] mlt_mid;
		logic [12:0] mlt_half_width;
		logic [23:0] top_height;
		logic [23:0] floor_height;
		logic [16:0] depth_scale;
		logic        cavity_enabled;
	} cdf_cfg_t;

	typedef struct packed {
		logic valid;
		logic hit;
	} cdf_ctl_t;

	typedef struct packed {
		cdf_ctl_t                  ctl;
		logic                      hlow;
		logic [2:0]                neg;
		logic [2:0]                zero;
		logic [2:0][MAG_W-1:0]     mag;
		logic [2:0][DEN_W-1:0]     den;
	} cdf_div_in_t;

	// one restoring step: quotient bit on top, new remainder below
	function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
			input logic nbit, input logic [DEN_W-1:0] den);
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		trial = {rem, nbit};
		diff = trial - {1'b0, den};
		if (trial >= {1'b0, den}) begin
			div_step = {1'b1, diff[DEN_W-1:0]};
		end else begin
			div_step = {1'b0, trial[DEN_W-1:0]};
		end
	endfunction
endpackage
`default_nettype wire

FILE: sv/cdf_front.sv
// window tests, midnight wrap and divider operand setup
`default_nettype none
module cdf_front import cdf_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire signed [24:0] height,
	input  wire signed [15:0] inv_lat,
	input  wire        [12:0] local_time,
	input  cdf_cfg_t          cfg,
	output cdf_div_in_t       front_s1
);
	logic signed [17:0] lat_x, lat_lo, lat_hi, dx, dx_abs;
	logic signed [26:0] h_x, top_x, flr_x, hnum, hnum_abs;
	logic signed [16:0] lt0, lt1, lt2, mmin, mmax, dy, dy_abs, day;
	logic               lat_in, h_in, lt_in, hlow;
	cdf_div_in_t        nxt;

	always_comb begin
		day = 17'(DAY_UNITS);
		lat_x = {{2{inv_lat[15]}}, inv_lat};
		lat_lo = $signed({3'b0, cfg.ilat_mid}) - $signed({3'b0, cfg.ilat_half_width});
		lat_hi = $signed({3'b0, cfg.ilat_mid}) + $signed({3'b0, cfg.ilat_half_width});
		lat_in = (lat_x >= lat_lo) && (lat_x <= lat_hi);

		h_x = {{2{height[24]}}, height};
		top_x = {3'b0, cfg.top_height};
		flr_x = {3'b0, cfg.floor_height};
		h_in = (h_x <= top_x);

		mmin = $signed({4'b0, cfg.mlt_mid}) - $signed({4'b0, cfg.mlt_half_width});
		mmax = $signed({4'b0, cfg.mlt_mid}) + $signed({4'b0, cfg.mlt_half_width});
		lt0 = {4'b0, local_time};
		lt1 = (mmin < 0 && lt0 > mmax) ? lt0 - day : lt0;
		lt2 = (mmax > day && lt1 < mmin) ? lt1 + day : lt1;
		lt_in = (lt2 >= mmin) && (lt2 <= mmax);

		// below the floor the cosine branch divides by the floor height
		hlow = (h_x < flr_x);
		hnum = hlow ? h_x : h_x - flr_x;
		hnum_abs = (hnum < 0) ? -hnum : hnum;
		dx = lat_x - $signed({3'b0, cfg.ilat_mid});
		dx_abs = (dx < 0) ? -dx : dx;
		dy = lt2 - $signed({4'b0, cfg.mlt_mid});
		dy_abs = (dy < 0) ? -dy : dy;

		nxt.ctl.valid = start;
		nxt.ctl.hit = cfg.cavity_enabled & lat_in & h_in & lt_in;
		nxt.hlow = hlow;
		nxt.neg[LANE_H] = hnum[26];
		nxt.neg[LANE_X] = dx[17];
		nxt.neg[LANE_Y] = dy[16];
		nxt.mag[LANE_H] = hnum_abs[MAG_W-1:0];
		nxt.mag[LANE_X] = {7'b0, dx_abs};
		nxt.mag[LANE_Y] = {8'b0, dy_abs};
		nxt.den[LANE_H] = hlow ? cfg.floor_height : cfg.top_height - cfg.floor_height;
		nxt.den[LANE_X] = {9'b0, cfg.ilat_half_width};
		nxt.den[LANE_Y] = {11'b0, cfg.mlt_half_width};
		nxt.zero[LANE_H] = (nxt.den[LANE_H] == '0);
		nxt.zero[LANE_X] = (nxt.den[LANE_X] == '0);
		nxt.zero[LANE_Y] = (nxt.den[LANE_Y] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_s1.ctl.valid <= 1'b0;
		end else begin
			front_s1 <= nxt;
		end
	end
endmodule
`default_nettype wire

FILE: sv/cdf_div.sv
// three-lane pipelined restoring divider, one quotient bit per stage, then phase setup
`default_nettype none
module cdf_div import cdf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  cdf_div_in_t         din,
	output cdf_ctl_t            ctl_o,
	output logic [FRAC_BITS+1:0] ph_h,
	output logic [FRAC_BITS+1:0] ph_x,
	output logic [FRAC_BITS+1:0] ph_y,
	output logic [FRAC_BITS+1:0] ph_yc
);
	localparam int F = FRAC_BITS;
	localparam int NW = MAG_W + F;
	localparam int QW = F + 2;
	localparam logic [QW-1:0] ONE_Q = {2'b01, {F{1'b0}}};

	cdf_div_in_t                 st_s  [0:NW];
	logic [2:0][DEN_W-1:0]       rem_s [0:NW];
	logic [2:0][QW-1:0]          quo_s [0:NW];

	assign st_s[0] = din;
	assign rem_s[0] = '0;
	assign quo_s[0] = '0;

	// only the low quotient bits survive: phase is taken modulo four quarter turns
	for (genvar k = 0; k < NW; k++) begin : g_stage
		localparam int BITPOS = NW - 1 - k;
		logic [2:0][DEN_W:0] step;
		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic nbit;
			if (BITPOS >= F) begin : g_data
				assign nbit = st_s[k].mag[l][BITPOS-F];
			end else begin : g_pad
				assign nbit = 1'b0;
			end
			assign step[l] = div_step(rem_s[k][l], nbit, st_s[k].den[l]);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st_s[k+1].ctl.valid <= 1'b0;
			end else begin
				st_s[k+1] <= st_s[k];
				for (int l = 0; l < 3; l++) begin
					rem_s[k+1][l] <= step[l][DEN_W-1:0];
					quo_s[k+1][l] <= {quo_s[k][l][QW-2:0], step[l][DEN_W]};
				end
			end
		end
	end

	logic [QW-1:0] sh, sx, sy;

	always_comb begin
		sh = st_s[NW].neg[LANE_H] ? -quo_s[NW][LANE_H] : quo_s[NW][LANE_H];
		sx = st_s[NW].neg[LANE_X] ? -quo_s[NW][LANE_X] : quo_s[NW][LANE_X];
		sy = st_s[NW].neg[LANE_Y] ? -quo_s[NW][LANE_Y] : quo_s[NW][LANE_Y];
		// zero height span counts as a full quarter turn
		if (st_s[NW].zero[LANE_H]) begin
			sh = ONE_Q;
		end
		if (st_s[NW].zero[LANE_X]) begin
			sx = '0;
		end
		if (st_s[NW].zero[LANE_Y]) begin
			sy = '0;
		end
		if (st_s[NW].hlow) begin
			sh = sh + ONE_Q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o.valid <= 1'b0;
		end else begin
			ctl_o <= st_s[NW].ctl;
			ph_h <= sh;
			ph_x <= sx;
			ph_y <= sy;
			ph_yc <= sy + ONE_Q;
		end
	end
endmodule
`default_nettype wire

FILE: sv/cdf_sinsq.sv
// squared sine of a quarter-turn phase, five multiply stages
`default_nettype none
module cdf_sinsq import cdf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire                  clk,
	input  wire [FRAC_BITS+1:0]  phase,
	output logic [FRAC_BITS:0]   sq
);
	localparam int F = FRAC_BITS;
	localparam int VW = F + 1;
	localparam int CW = F + 2;
	localparam int PW = VW + CW;
	localparam logic [VW-1:0] ONE_V = {1'b1, {F{1'b0}}};
	localparam logic [CW-1:0] ONE_C = {2'b01, {F{1'b0}}};
	localparam logic [CW-1:0] COEF_A = CW'(64'd1686629713 >> (30 - F));
	localparam logic [CW-1:0] COEF_B = CW'(64'd693598564 >> (30 - F));
	localparam logic [CW-1:0] COEF_C = CW'(64'd80710675 >> (30 - F));

	logic [VW-1:0]   xf;
	logic [2*VW-1:0] p1, p5;
	logic [PW-1:0]   p2, p3, p4;
	logic [CW-1:0]   rr;

	logic [VW-1:0] x_s1, x2_s1, x_s2, x2_s2, x_s3, r_s4, sq_s5;
	logic [CW-1:0] t1_s2, t_s3;

	// odd quadrants run the fraction backwards; sign is lost in the square
	assign xf = phase[F] ? ONE_V - {1'b0, phase[F-1:0]} : {1'b0, phase[F-1:0]};
	assign p1 = xf * xf;
	assign p2 = x2_s1 * COEF_C;
	assign p3 = x2_s2 * t1_s2;
	assign p4 = x_s3 * t_s3;
	assign rr = p4[F+CW-1:F];
	assign p5 = r_s4 * r_s4;

	always_ff @(posedge clk) begin
		x_s1 <= xf;
		x2_s1 <= p1[F+VW-1:F];
		x_s2 <= x_s1;
		x2_s2 <= x2_s1;
		t1_s2 <= COEF_B - p2[F+CW-1:F];
		x_s3 <= x_s2;
		t_s3 <= COEF_A - p3[F+CW-1:F];
		r_s4 <= (rr > ONE_C) ? ONE_V : rr[VW-1:0];
		sq_s5 <= p5[F+VW-1:F];
	end

	assign sq = sq_s5;
endmodule
`default_nettype wire

FILE: sv/cdf_blend.sv
// height profile and bowl blend, final square and result register
`default_nettype none
module cdf_blend import cdf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  cdf_ctl_t           ctl_i,
	input  wire [FRAC_BITS:0]  hf2,
	input  wire [FRAC_BITS:0]  sx2,
	input  wire [FRAC_BITS:0]  sy2,
	input  wire [FRAC_BITS:0]  cy2,
	input  wire [16:0]         depth_scale,
	output logic               done,
	output logic [16:0]        gain,
	output logic               inside_res
);
	localparam int F = FRAC_BITS;
	localparam int VW = F + 1;
	localparam int UP = (F >= 16) ? F - 16 : 0;
	localparam int DN = (F < 16) ? 16 - F : 0;
	localparam logic [VW-1:0] ONE_V = {1'b1, {F{1'b0}}};

	logic [25:0]     s_w;
	logic [VW-1:0]   s_v;
	logic [2*VW-1:0] pb, pbx, pg, pgg;
	logic [VW:0]     bowl_sum;
	logic [VW+7:0]   gx;

	logic [VW-1:0] base_s1, bowl_s1, g_s2;
	cdf_ctl_t      ctl_s1, ctl_s2;
	logic          done_q, inside_q;
	logic [16:0]   gain_q;

	always_comb begin
		s_w = ({9'b0, depth_scale} << UP) >> DN;
		s_v = (s_w > 26'(ONE_V)) ? ONE_V : s_w[VW-1:0];
		pb = (ONE_V - s_v) * hf2;
		pbx = sx2 * cy2;
		bowl_sum = {1'b0, pbx[F+VW-1:F]} + {1'b0, sy2};
		pg = (ONE_V - base_s1) * bowl_s1;
		pgg = g_s2 * g_s2;
		gx = ({8'b0, pgg[F+VW-1:F]} << DN) >> UP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1.valid <= 1'b0;
			ctl_s2.valid <= 1'b0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl_i;
			base_s1 <= pb[F+VW-1:F] + s_v;
			bowl_s1 <= (bowl_sum > {1'b0, ONE_V}) ? ONE_V : bowl_sum[VW-1:0];
			ctl_s2 <= ctl_s1;
			g_s2 <= pg[F+VW-1:F] + base_s1;
			done_q <= ctl_s2.valid;
			inside_q <= ctl_s2.hit;
			gain_q <= ctl_s2.hit ? gx[16:0] : 17'd65536;
		end
	end

	assign done = done_q;
	assign gain = gain_q;
	assign inside_res = inside_q;
endmodule
`default_nettype wire

FILE: sv/cavity_density_factor.sv
// top level: config registers, front end, divider, sine squares and blend
//
//  port group   direction  handshake          payload
//  item in      in         start, busy        height, inv_lat, local_time
//  result out   out        done (one cycle)   gain, inside_res
//  config       in         cfg_we             cfg_index, cfg_wdata
//
// a new item is taken every cycle; busy is always low
// the divider resolves one quotient bit per stage
// reset clears the valid bits and loads the register defaults
// results cannot be held off, so the pipeline never stalls
`default_nettype none
module cavity_density_factor import cdf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire signed [24:0] height,
	input  wire signed [15:0] inv_lat,
	input  wire        [12:0] local_time,
	output logic              done,
	output logic       [16:0] gain,
	output logic              inside_res,
	input  wire               cfg_we,
	input  wire        [2:0]  cfg_index,
	input  wire        [23:0] cfg_wdata
);
	localparam int SIN_LAT = 5;

	cdf_cfg_t            cfg_q;
	cdf_div_in_t         front_s1;
	cdf_ctl_t            div_ctl;
	cdf_ctl_t            ctl_dly_q [0:SIN_LAT-1];
	logic [FRAC_BITS+1:0] ph_h, ph_x, ph_y, ph_yc;
	logic [FRAC_BITS:0]   hf2, sx2, sy2, cy2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ilat_mid <= 15'd1;
			cfg_q.ilat_half_width <= 15'd1;
			cfg_q.mlt_mid <= 13'd0;
			cfg_q.mlt_half_width <= 13'd1;
			cfg_q.top_height <= 24'd0;
			cfg_q.floor_height <= 24'd0;
			cfg_q.depth_scale <= 17'd65536;
			cfg_q.cavity_enabled <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ILAT_MID: cfg_q.ilat_mid <= cfg_wdata[14:0];
				REG_ILAT_HALF_WIDTH: cfg_q.ilat_half_width <= cfg_wdata[14:0];
				REG_MLT_MID: cfg_q.mlt_mid <= cfg_wdata[12:0];
				REG_MLT_HALF_WIDTH: cfg_q.mlt_half_width <= cfg_wdata[12:0];
				REG_TOP_HEIGHT: cfg_q.top_height <= cfg_wdata;
				REG_FLOOR_HEIGHT: cfg_q.floor_height <= cfg_wdata;
				REG_DEPTH_SCALE: cfg_q.depth_scale <= cfg_wdata[16:0];
				REG_CAVITY_ENABLED: cfg_q.cavity_enabled <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	cdf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.height     (height),
		.inv_lat    (inv_lat),
		.local_time (local_time),
		.cfg        (cfg_q),
		.front_s1   (front_s1)
	);

	cdf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (front_s1),
		.ctl_o  (div_ctl),
		.ph_h   (ph_h),
		.ph_x   (ph_x),
		.ph_y   (ph_y),
		.ph_yc  (ph_yc)
	);

	cdf_sinsq #(.FRAC_BITS(FRAC_BITS)) u_sin_h (.clk(clk), .phase(ph_h), .sq(hf2));
	cdf_sinsq #(.FRAC_BITS(FRAC_BITS)) u_sin_x (.clk(clk), .phase(ph_x), .sq(sx2));
	cdf_sinsq #(.FRAC_BITS(FRAC_BITS)) u_sin_y (.clk(clk), .phase(ph_y), .sq(sy2));
	cdf_sinsq #(.FRAC_BITS(FRAC_BITS)) u_cos_y (.clk(clk), .phase(ph_yc), .sq(cy2));

	// item control rides alongside the sine stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SIN_LAT; i++) begin
				ctl_dly_q[i].valid <= 1'b0;
			end
		end else begin
			ctl_dly_q[0] <= div_ctl;
			for (int i = 1; i < SIN_LAT; i++) begin
				ctl_dly_q[i] <= ctl_dly_q[i-1];
			end
		end
	end

	cdf_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl_i       (ctl_dly_q[SIN_LAT-1]),
		.hf2         (hf2),
		.sx2         (sx2),
		.sy2         (sy2),
		.cy2         (cy2),
		.depth_scale (cfg_q.depth_scale),
		.done        (done),
		.gain        (gain),
		.inside_res  (inside_res)
	);
endmodule
`default_nettype wire

FILE: verif/tb.sv
// self-checking testbench for the cavity density factor block
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import cdf_pkg::*;

	localparam longint unsigned ONE = 64'd1 << 16;
	localparam longint unsigned SIN_A = 64'd1686629713 >> 14;
	localparam longint unsigned SIN_B = 64'd693598564 >> 14;
	localparam longint unsigned SIN_C = 64'd80710675 >> 14;
	localparam int LATENCY = 51;

	typedef struct {
		logic signed [24:0] height;
		logic signed [15:0] inv_lat;
		logic        [12:0] local_time;
	} point_t;

	typedef struct {
		logic [16:0] gain;
		logic        hit;
	} gain_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [24:0] height = '0;
	logic signed [15:0] inv_lat = '0;
	logic [12:0] local_time = '0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_ILAT_MID;
	logic [23:0] cfg_wdata = '0;
	wire busy, done, inside_res;
	wire [16:0] gain;

	cdf_cfg_t regs;
	point_t points_pending[$];
	gain_t gains_expected[$];
	int idle_pct = 0;
	int mismatches = 0;

	cavity_density_factor dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.height(height), .inv_lat(inv_lat), .local_time(local_time),
		.done(done), .gain(gain), .inside_res(inside_res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint unsigned qmul(input longint unsigned a, input longint unsigned b);
		return (a * b) >> 16;
	endfunction

	function automatic longint unsigned sin_arc(input longint unsigned x);
		longint unsigned x2, t, r;
		x2 = qmul(x, x);
		t = SIN_B - qmul(x2, SIN_C);
		t = SIN_A - qmul(x2, t);
		r = qmul(x, t);
		return (r > ONE) ? ONE : r;
	endfunction

	// p in quarter turns, reduced modulo a full turn
	function automatic longint sin_turns(input longint p);
		longint unsigned q, quad, f;
		longint v;
		q = p & ((ONE << 2) - 1);
		quad = q >> 16;
		f = q & (ONE - 1);
		if (quad[0]) begin
			f = ONE - f;
		end
		v = longint'(sin_arc(f));
		return (quad >= 2) ? -v : v;
	endfunction

	function automatic longint unsigned square(input longint v);
		longint unsigned m;
		m = (v < 0) ? -v : v;
		return qmul(m, m);
	endfunction

	function automatic longint ratio(input longint num, input longint unsigned den,
			input longint guard);
		longint unsigned m;
		longint r;
		if (den == 0) begin
			return guard;
		end
		m = (num < 0) ? -num : num;
		r = longint'((m << 16) / den);
		return (num < 0) ? -r : r;
	endfunction

	function automatic gain_t cavity_gain(input cdf_cfg_t c, input point_t pt);
		longint h, lat, lt, lc, lw, mmin, mmax, top, flr, hf, px, py;
		longint unsigned s, base, bowl, cy2, g;
		gain_t r;
		h = pt.height;
		lat = pt.inv_lat;
		lt = pt.local_time;
		lc = c.ilat_mid;
		lw = c.ilat_half_width;
		mmin = longint'(c.mlt_mid) - longint'(c.mlt_half_width);
		mmax = longint'(c.mlt_mid) + longint'(c.mlt_half_width);
		top = c.top_height;
		flr = c.floor_height;
		r.gain = 17'd65536;
		r.hit = 1'b0;
		if (!c.cavity_enabled || lat < lc - lw || lat > lc + lw || h > top) begin
			return r;
		end
		// midnight wrap of the local-time window
		if (mmin < 0 && lt > mmax) begin
			lt -= DAY_UNITS;
		end
		if (mmax > DAY_UNITS && lt < mmin) begin
			lt += DAY_UNITS;
		end
		if (lt < mmin || lt > mmax) begin
			return r;
		end
		if (h < flr) begin
			hf = sin_turns(ratio(h, flr, ONE) + ONE);
		end else begin
			hf = sin_turns(ratio(h - flr, top - flr, ONE));
		end
		s = c.depth_scale;
		if (s > ONE) begin
			s = ONE;
		end
		base = qmul(ONE - s, square(hf)) + s;
		px = ratio(lat - lc, lw, 0);
		py = ratio(lt - longint'(c.mlt_mid), c.mlt_half_width, 0);
		cy2 = square(sin_turns(py + ONE));
		bowl = qmul(square(sin_turns(px)), cy2) + square(sin_turns(py));
		if (bowl > ONE) begin
			bowl = ONE;
		end
		g = qmul(ONE - base, bowl) + base;
		r.gain = 17'(qmul(g, g));
		r.hit = 1'b1;
		return r;
	endfunction

	// item driver
	always @(posedge clk) begin
		point_t pt;
		if (start && !busy) begin
			pt.height = height;
			pt.inv_lat = inv_lat;
			pt.local_time = local_time;
			gains_expected.push_back(cavity_gain(regs, pt));
		end
		if (!start || !busy) begin
			if (points_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
				pt = points_pending.pop_front();
				start <= 1'b1;
				height <= pt.height;
				inv_lat <= pt.inv_lat;
				local_time <= pt.local_time;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		gain_t want;
		if (done) begin
			if (gains_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result gain=%0d inside=%0d", gain, inside_res);
				end
			end else begin
				want = gains_expected.pop_front();
				if (gain !== want.gain || inside_res !== want.hit) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected gain=%0d inside=%0d, got gain=%0d inside=%0d",
							want.gain, want.hit, gain, inside_res);
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_ILAT_MID: regs.ilat_mid = val[14:0];
			REG_ILAT_HALF_WIDTH: regs.ilat_half_width = val[14:0];
			REG_MLT_MID: regs.mlt_mid = val[12:0];
			REG_MLT_HALF_WIDTH: regs.mlt_half_width = val[12:0];
			REG_TOP_HEIGHT: regs.top_height = val;
			REG_FLOOR_HEIGHT: regs.floor_height = val;
			REG_DEPTH_SCALE: regs.depth_scale = val[16:0];
			default: regs.cavity_enabled = val[0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_regs(input int lc, input int lw, input int mc, input int mw,
			input int top, input int flr, input int ds, input int en);
		write_reg(REG_ILAT_MID, 24'(lc));
		write_reg(REG_ILAT_HALF_WIDTH, 24'(lw));
		write_reg(REG_MLT_MID, 24'(mc));
		write_reg(REG_MLT_HALF_WIDTH, 24'(mw));
		write_reg(REG_TOP_HEIGHT, 24'(top));
		write_reg(REG_FLOOR_HEIGHT, 24'(flr));
		write_reg(REG_DEPTH_SCALE, 24'(ds));
		write_reg(REG_CAVITY_ENABLED, 24'(en));
	endtask

	task automatic add_point(input int h, input int lat, input int lt);
		point_t pt;
		pt.height = 25'(h);
		pt.inv_lat = 16'(lat);
		pt.local_time = 13'(lt);
		points_pending.push_back(pt);
	endtask

	// mostly points aimed at the window, the rest anywhere
	task automatic add_random_point();
		int h, lat, lt, w;
		if ($urandom_range(99) < 25) begin
			h = int'($urandom_range(33554431)) - 16777216;
			lat = int'($urandom_range(65535)) - 32768;
			lt = $urandom_range(8191);
		end else begin
			w = regs.ilat_half_width;
			lat = int'(regs.ilat_mid) + int'($urandom_range(2 * w + 2)) - w - 1;
			if (lat > 32767) lat = 32767;
			w = regs.mlt_half_width;
			lt = int'(regs.mlt_mid) + int'($urandom_range(2 * w + 2)) - w - 1;
			if (lt < 0) lt += DAY_UNITS;
			if (lt >= DAY_UNITS) lt -= DAY_UNITS;
			case ($urandom_range(3))
				0: h = int'($urandom_range(regs.floor_height));
				1: h = int'($urandom_range(regs.top_height));
				2: h = -int'($urandom_range(16777216));
				default: h = int'(regs.top_height) + int'($urandom_range(2)) - 1;
			endcase
		end
		add_point(h, lat, lt);
	endtask

	task automatic drain();
		while (points_pending.size() > 0 || start || gains_expected.size() > 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int flr;
		regs = '{ilat_mid: 1, ilat_half_width: 1, mlt_mid: 0, mlt_half_width: 1,
			top_height: 0, floor_height: 0, depth_scale: 65536, cavity_enabled: 0};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled after reset
		add_point(0, 1, 0);
		add_point(-16777216, -23040, 6143);
		drain();

		load_regs(11520, 23040, 3072, 6144, 16777215, 8388608, 0, 1);
		add_point(16777215, 23040, 6143);
		add_point(-16777216, -23040, 0);
		add_point(8388608, 11520, 3072);
		add_point(0, 0, 8191);
		add_point(4194304, 20000, 100);
		add_point(-1, -11520, 6000);
		drain();

		// zero height span and zero half widths
		load_regs(100, 0, 6143, 0, 5000, 5000, 131071, 1);
		add_point(5000, 100, 6143);
		add_point(4000, 100, 6143);
		add_point(5001, 100, 6143);
		drain();
		load_regs(23039, 23040, 10, 200, 0, 0, 30000, 1);
		add_point(-5, 0, 6100);
		add_point(0, 23040, 100);
		add_point(-16777216, 32767, 150);
		add_point(-100, -32768, 6000);
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: idle_pct = 0;
				1: idle_pct = 55;
				2: idle_pct = 0;
				default: idle_pct = 37;
			endcase
			flr = $urandom_range(16777215);
			load_regs($urandom_range(1, 23039),
				($urandom_range(3) == 0) ? $urandom_range(1, 23040) : $urandom_range(1, 3000),
				$urandom_range(6143),
				($urandom_range(3) == 0) ? $urandom_range(1, 6144) : $urandom_range(1, 800),
				$urandom_range(flr, 16777215),
				($urandom_range(4) == 0) ? $urandom_range(16777215) : flr,
				($urandom_range(4) == 0) ? $urandom_range(131071) : $urandom_range(65536),
				($urandom_range(7) != 0));
			repeat (92) add_random_point();
			drain();
		end

		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && gains_expected.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire

FILE: files.f
sv/cdf_pkg.sv
sv/cdf_front.sv
sv/cdf_div.sv
sv/cdf_sinsq.sv
sv/cdf_blend.sv
sv/cavity_density_factor.sv
verif/tb.sv
